// ----- rtl/sfl_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Size-sorted free list package
// Shared types and constants for the size-sorted free block table.
// ----------------------------------------------------------------------------
package sfl_pkg;

  localparam int DefTableDepth  = 32;
  localparam int DefAddressBits = 32;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_FIT    = 2'd2,
    ACT_LAST   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_MISS  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE    = 2'd0,
    S_EXEC    = 2'd1,
    S_RESPOND = 2'd2
  } fsm_state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } sfl_cmd_t;

  typedef struct packed {
    logic dummy;
  } sfl_stat_t;

endpackage
`default_nettype wire

// ----- rtl/sorted_free_list_best_fit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Size-sorted free list, best fit
// A request is captured, then the entry cell chain compares and shifts and
// the result register loads; a new request is accepted only when the
// previous result is taken.
// Reset clears the entry count and controller; entries need no clearing.
// ----------------------------------------------------------------------------
module sorted_free_list_best_fit
  import sfl_pkg::*;
#(
  parameter int TableDepth  = DefTableDepth,
  parameter int AddressBits = DefAddressBits
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  action,
  input  wire logic [31:0] block_address,
  input  wire logic [31:0] block_size,
  input  wire logic [31:0] request_size,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             found,
  output logic [31:0]      result_address,
  output logic [31:0]      result_size,
  output logic [1:0]       status
);

  sfl_cmd_t cmd;

  sfl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_taken (out_ready),
    .out_busy  (out_valid),
    .cmd       (cmd)
  );

  sfl_dp #(
    .TableDepth  (TableDepth),
    .AddressBits (AddressBits)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .action         (action),
    .block_address  (block_address),
    .block_size     (block_size),
    .request_size   (request_size),
    .found          (found),
    .result_address (result_address),
    .result_size    (result_size),
    .status         (status)
  );

  a_one_cycle_work: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid ##1 out_valid)
    else $error("result not presented two cycles after request");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> (status == ST_OK))
    else $error("found result with bad status");

  a_no_accept_in_work: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while busy");

endmodule
`default_nettype wire

// ----- rtl/sfl_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Size-sorted free list controller
// Sequences one request: capture, table update, result hand-off.
// ----------------------------------------------------------------------------
module sfl_ctrl
  import sfl_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire logic     out_taken,
  output logic          out_busy,
  output sfl_cmd_t      cmd
);

  fsm_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (in_valid) state_next = S_EXEC;
      S_EXEC:    state_next = S_RESPOND;
      S_RESPOND: if (out_taken) state_next = in_valid ? S_EXEC : S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    out_busy = 1'b0;
    cmd      = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_EXEC: cmd.exec = 1'b1;
      S_RESPOND: begin
        out_busy = 1'b1;
        in_ready = out_taken;
        cmd.load = out_taken && in_valid;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/sfl_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Size-sorted free list datapath
// Cell chain of entries with parallel compare and shift.
// ----------------------------------------------------------------------------
module sfl_dp
  import sfl_pkg::*;
#(
  parameter int TableDepth  = DefTableDepth,
  parameter int AddressBits = DefAddressBits
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire sfl_cmd_t    cmd,
  input  wire logic [1:0]  action,
  input  wire logic [31:0] block_address,
  input  wire logic [31:0] block_size,
  input  wire logic [31:0] request_size,
  output logic             found,
  output logic [31:0]      result_address,
  output logic [31:0]      result_size,
  output logic [1:0]       status
);

  localparam int CntW = $clog2(TableDepth + 1);
  localparam int IdxW = $clog2(TableDepth);

  logic [AddressBits-1:0] addrs [TableDepth];
  logic [31:0]            sizes [TableDepth];
  logic [CntW-1:0]        count;

  action_t                req_act;
  logic [AddressBits-1:0] req_addr;
  logic [31:0]            req_bsize;
  logic [31:0]            req_rsize;

  logic [TableDepth-1:0] live, gt_ins, ge_req, addr_eq;
  logic [TableDepth-1:0] ins_shift, rem_shift, fit_first;
  logic                  ge_seen;
  logic                  full, empty, rem_hit, fit_hit;
  logic [AddressBits-1:0] fit_addr, last_addr;
  logic [31:0]           fit_size, last_size;
  logic [IdxW-1:0]       last_idx;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_act   <= action_t'(action);
      req_addr  <= AddressBits'({32'd0, block_address} & {64{1'b1}});
      req_bsize <= block_size;
      req_rsize <= request_size;
    end
  end

  always_comb begin
    for (int i = 0; i < TableDepth; i++) begin
      live[i]    = CntW'(i) < count;
      gt_ins[i]  = live[i] && (sizes[i] > req_bsize);
      ge_req[i]  = live[i] && (sizes[i] >= req_rsize);
      addr_eq[i] = live[i] && (addrs[i] == req_addr);
    end
  end

  // Prefix-or vectors: entry i shifts when an earlier or equal entry matched.
  always_comb begin
    ins_shift[0] = gt_ins[0];
    rem_shift[0] = addr_eq[0];
    for (int i = 1; i < TableDepth; i++) begin
      ins_shift[i] = ins_shift[i-1] | gt_ins[i];
      rem_shift[i] = rem_shift[i-1] | addr_eq[i];
    end
    fit_first[0] = ge_req[0];
    ge_seen      = ge_req[0];
    for (int i = 1; i < TableDepth; i++) begin
      fit_first[i] = ge_req[i] & ~ge_seen;
      ge_seen      = ge_seen | ge_req[i];
    end
  end

  always_comb begin
    fit_addr = '0;
    fit_size = '0;
    for (int i = 0; i < TableDepth; i++) begin
      if (fit_first[i]) begin
        fit_addr = fit_addr | addrs[i];
        fit_size = fit_size | sizes[i];
      end
    end
  end

  assign full      = count == CntW'(TableDepth);
  assign empty     = count == '0;
  assign rem_hit   = |addr_eq;
  assign fit_hit   = |ge_req;
  assign last_idx  = IdxW'(count - CntW'(1));
  assign last_addr = addrs[last_idx];
  assign last_size = sizes[last_idx];

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < TableDepth; i++) begin
        if (req_act == ACT_INSERT && !full) begin
          if (i == 0) begin
            if (ins_shift[0] || empty) begin
              addrs[0] <= req_addr;
              sizes[0] <= req_bsize;
            end
          end else if (ins_shift[i-1]) begin
            addrs[i] <= addrs[i-1];
            sizes[i] <= sizes[i-1];
          end else if (ins_shift[i] || CntW'(i) == count) begin
            addrs[i] <= req_addr;
            sizes[i] <= req_bsize;
          end
        end else if (req_act == ACT_REMOVE && rem_hit) begin
          if (i < TableDepth - 1 && rem_shift[i]) begin
            addrs[i] <= addrs[i+1];
            sizes[i] <= sizes[i+1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      if (req_act == ACT_INSERT && !full) count <= count + CntW'(1);
      else if (req_act == ACT_REMOVE && rem_hit) count <= count - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      found          <= 1'b0;
      result_address <= '0;
      result_size    <= '0;
      status         <= ST_OK;
      case (req_act)
        ACT_INSERT: if (full) status <= ST_FULL;
        ACT_REMOVE: if (!rem_hit) status <= ST_MISS;
        ACT_FIT: begin
          if (fit_hit) begin
            found          <= 1'b1;
            result_address <= 32'({64'd0, fit_addr});
            result_size    <= fit_size;
          end else begin
            status <= ST_MISS;
          end
        end
        ACT_LAST: begin
          if (empty) begin
            status <= ST_EMPTY;
          end else begin
            found          <= 1'b1;
            result_address <= 32'({64'd0, last_addr});
            result_size    <= last_size;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- tb/sfl_checker.sv -----
// ----------------------------------------------------------------------------
// Free list result checker
// Watches both channels of the size-sorted free list, keeps its own sorted
// table of free blocks, predicts the result of every accepted request and
// compares each returned result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module sfl_checker
  import sfl_pkg::*;
#(
  parameter int Depth = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [1:0]  action,
  input  wire logic [31:0] block_address,
  input  wire logic [31:0] block_size,
  input  wire logic [31:0] request_size,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic        found,
  input  wire logic [31:0] result_address,
  input  wire logic [31:0] result_size,
  input  wire logic [1:0]  status,
  output int               errors,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        found;
    logic [31:0] address;
    logic [31:0] size;
    status_t     status;
  } alloc_result_t;

  logic [31:0] free_addr[Depth];
  logic [31:0] free_size[Depth];
  int free_count;
  alloc_result_t expected_results[$];

  assign pending = expected_results.size();

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic alloc_result_t predict_allocation(input action_t act,
      input logic [31:0] addr, input logic [31:0] bsize, input logic [31:0] rsize);
    alloc_result_t r;
    int pos;
    int hit;
    r = '{found: 1'b0, address: '0, size: '0, status: ST_OK};
    case (act)
      ACT_INSERT: begin
        if (free_count >= Depth) begin
          r.status = ST_FULL;
        end else begin
          pos = free_count;
          for (int i = free_count - 1; i >= 0; i--) begin
            if (free_size[i] > bsize) pos = i;
          end
          for (int i = free_count; i > pos; i--) begin
            free_addr[i] = free_addr[i-1];
            free_size[i] = free_size[i-1];
          end
          free_addr[pos] = addr;
          free_size[pos] = bsize;
          free_count++;
        end
      end
      ACT_REMOVE: begin
        hit = -1;
        for (int i = free_count - 1; i >= 0; i--) begin
          if (free_addr[i] == addr) hit = i;
        end
        if (hit < 0) begin
          r.status = ST_MISS;
        end else begin
          for (int i = hit; i + 1 < free_count; i++) begin
            free_addr[i] = free_addr[i+1];
            free_size[i] = free_size[i+1];
          end
          free_count--;
        end
      end
      ACT_FIT: begin
        hit = -1;
        for (int i = free_count - 1; i >= 0; i--) begin
          if (free_size[i] >= rsize) hit = i;
        end
        if (hit < 0) begin
          r.status = ST_MISS;
        end else begin
          r = '{found: 1'b1, address: free_addr[hit], size: free_size[hit], status: ST_OK};
        end
      end
      default: begin
        if (free_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r = '{found: 1'b1, address: free_addr[free_count-1],
                size: free_size[free_count-1], status: ST_OK};
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_result_t want;
    if (rst) begin
      free_count = 0;
      expected_results.delete();
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_allocation(action_t'(action), block_address,
                                                      block_size, request_size));
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result arrived with no request outstanding", $realtime);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (found !== want.found) report("found", 32'(found), 32'(want.found));
          if (result_address !== want.address) report("result_address", result_address,
                                                       want.address);
          if (result_size !== want.size) report("result_size", result_size, want.size);
          if (status !== want.status) report("status", 32'(status), 32'(want.status));
        end
      end
    end
  end

  initial errors = 0;
endmodule

// ----- tb/tb_sorted_free_list_best_fit.sv -----
// ----------------------------------------------------------------------------
// Size-sorted free list testbench
// Drives directed and random insert, remove and query requests with random
// idling on both sides and a long result stall; a checker judges results.
// ----------------------------------------------------------------------------
module tb_sorted_free_list_best_fit;
  import sfl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] action = ACT_INSERT;
  logic [31:0] block_address = '0;
  logic [31:0] block_size = '0;
  logic [31:0] request_size = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic found;
  logic [31:0] result_address;
  logic [31:0] result_size;
  logic [1:0] status;
  int errors;
  int pending;
  logic [31:0] used_addr[$];
  bit steady = 1'b0;
  bit hold_off = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sorted_free_list_best_fit i_dut (.*);

  sfl_checker i_checker (.*);

  task automatic send_request(input action_t act, input logic [31:0] addr,
      input logic [31:0] bsize, input logic [31:0] rsize);
    while (!steady && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    action <= act;
    block_address <= addr;
    block_size <= bsize;
    request_size <= rsize;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (act == ACT_INSERT) used_addr.push_back(addr);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(64);
    endcase
  endfunction

  function automatic logic [31:0] pick_address();
    if (used_addr.size() > 0 && $urandom_range(3) != 0)
      return used_addr[$urandom_range(used_addr.size() - 1)];
    return $urandom_range(3) == 0 ? $urandom : $urandom_range(255);
  endfunction

  always @(posedge clk) begin
    if (rst || hold_off) out_ready <= 1'b0;
    else out_ready <= steady || $urandom_range(99) >= 35;
  end

  initial begin
    logic [31:0] sz;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_request(ACT_LAST, 32'd1, 32'd0, 32'd0);
    send_request(ACT_FIT, 32'd0, 32'd0, 32'd0);
    send_request(ACT_REMOVE, 32'd5, 32'd0, 32'd0);
    send_request(ACT_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    send_request(ACT_INSERT, 32'd0, 32'd0, 32'd0);
    send_request(ACT_INSERT, 32'h100, 32'd16, 32'd0);
    send_request(ACT_INSERT, 32'h200, 32'd16, 32'd0);
    send_request(ACT_FIT, 32'd0, 32'd0, 32'd16);
    send_request(ACT_FIT, 32'd0, 32'd0, 32'hFFFF_FFFF);
    send_request(ACT_LAST, 32'd0, 32'd0, 32'd0);
    send_request(ACT_REMOVE, 32'd0, 32'd0, 32'd0);
    send_request(ACT_FIT, 32'd0, 32'd0, 32'd0);
    send_request(ACT_REMOVE, 32'h1234, 32'd0, 32'd0);
    for (int i = 0; i < 34; i++) begin
      send_request(ACT_INSERT, 32'h1000 + i, i[31:0], 32'd0);
    end
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        steady = 1'b1;
        for (int i = 0; i < 10; i++) send_request(ACT_FIT, 32'd0, 32'd0, i[31:0]);
      end
    join
    for (int i = 0; i < 1000; i++) begin
      steady = (i >= 400 && i < 550);
      sz = pick_value();
      case ($urandom_range(9))
        0, 1, 2: send_request(ACT_INSERT, pick_address(), sz, pick_value());
        3, 4, 5: send_request(ACT_REMOVE, pick_address(), sz, pick_value());
        6, 7: send_request(ACT_FIT, $urandom, sz, pick_value());
        default: send_request(ACT_LAST, $urandom, sz, $urandom);
      endcase
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #2ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/sfl_pkg.sv
rtl/sfl_ctrl.sv
rtl/sfl_dp.sv
rtl/sorted_free_list_best_fit.sv
tb/sfl_checker.sv
tb/tb_sorted_free_list_best_fit.sv
